### hdl/mbee_pkg.sv
// shared types and constants of the blocking error estimator
`default_nettype none
package mbee_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int BSUM_W     = 32;
    localparam int MSUM_W     = 48;
    localparam int SQSUM_W    = 64;
    localparam int CNT_W      = 16;
    localparam int MEAN_W     = 24;
    localparam int STD_W      = 23;
    localparam int LEN_W      = 8;
    localparam int WARM_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W      = 64;
    localparam int DVSR_W     = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int STEP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_ROWS  = 2'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        DIV_BSUM  = 2'd0,
        DIV_MSUM  = 2'd1,
        DIV_SQSUM = 2'd2,
        DIV_VAR   = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic       sample;
        logic       div_start;
        t_div_sel   div_sel;
        logic       cl_mul;
        logic       cl_acc;
        logic       blk_done;
        logic       lat_m1;
        logic       mul_step_en;
        logic [1:0] mul_step;
        logic       var_calc;
        logic       sq_init;
        logic       sq_step;
        logic       out_load;
        logic       out_last;
        logic       clear_all;
    } t_cmd;

    typedef struct packed {
        logic close_req;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### hdl/mbee_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module mbee_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mbee_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [mbee_pkg::DVSR_W-1:0] i_divisor,
    output logic                             o_busy,
    output logic [mbee_pkg::DIV_W-1:0]       o_quotient
);
    import mbee_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DVSR_W-1:0]    r_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DVSR_W:0]      trial;
    logic [DVSR_W:0]      diff;
    logic                 fits;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        diff  = trial - {1'b0, r_dvsr};
        fits  = trial >= {1'b0, r_dvsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

### hdl/mbee_dp.sv
// datapath: per-channel sums, counters, multiplier, square root and result register
`default_nettype none
module mbee_dp #(
    parameter int CHANNELS = 16,
    parameter int CW       = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mbee_pkg::t_cmd                    i_cmd,
    input  wire logic [CW-1:0]                     i_ch_idx,
    output mbee_pkg::t_sts                         o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [mbee_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mbee_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [3:0]                        i_channel,
    input  wire logic signed [mbee_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire logic                              i_row_end,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic [3:0]                             o_out_channel,
    output logic signed [mbee_pkg::MEAN_W-1:0]     o_mean_value,
    output logic [mbee_pkg::STD_W-1:0]             o_std_error,
    output logic [mbee_pkg::CNT_W-1:0]             o_blocks_used,
    output logic                                   o_stats_valid,
    output logic                                   o_last_result
);
    import mbee_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = '1;

    logic [LEN_W-1:0]   r_blk_len;
    logic [WARM_W-1:0]  r_warm;
    logic [LEN_W-1:0]   r_rib;
    logic [WARM_W-1:0]  r_skip;
    logic [CNT_W-1:0]   r_bcnt;
    logic [BSUM_W-1:0]  r_bsum  [CHANNELS];
    logic [MSUM_W-1:0]  r_msum  [CHANNELS];
    logic [SQSUM_W-1:0] r_sqsum [CHANNELS];

    logic [BSUM_W-1:0]        r_m;
    logic [63:0]              r_prod;
    logic signed [MSUM_W-1:0] r_m1;
    logic [MSUM_W-1:0]        r_m1mag;
    logic [63:0]              r_m2, r_sq, r_var, r_x, r_res, r_bit;
    logic                     r_ovalid;

    logic [LEN_W-1:0]   len;
    logic               warming;
    logic               ch_ok;
    logic [CW-1:0]      sidx;
    logic [BSUM_W-1:0]  cur_bsum, bsum_mag;
    logic [MSUM_W-1:0]  cur_msum, msum_mag;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVSR_W-1:0]  div_divisor;
    logic               div_busy;
    logic [DIV_W-1:0]   quot;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        sq_trial;
    logic               out_free;

    always_comb begin
        len       = (r_blk_len == '0) ? LEN_W'(1) : r_blk_len;
        warming   = r_skip < r_warm;
        ch_ok     = int'(i_channel) < CHANNELS;
        sidx      = CW'(i_channel);
        cur_bsum  = r_bsum[i_ch_idx];
        cur_msum  = r_msum[i_ch_idx];
        bsum_mag  = cur_bsum[BSUM_W-1] ? (~cur_bsum + 1'b1) : cur_bsum;
        msum_mag  = cur_msum[MSUM_W-1] ? (~cur_msum + 1'b1) : cur_msum;
        out_free  = !r_ovalid || !i_out_stall;
        sq_trial  = r_res + r_bit;
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_BSUM:  div_dividend = {{(DIV_W-BSUM_W){1'b0}}, bsum_mag};
            DIV_MSUM:  div_dividend = {{(DIV_W-MSUM_W){1'b0}}, msum_mag};
            DIV_SQSUM: div_dividend = r_sqsum[i_ch_idx];
            DIV_VAR:   div_dividend = r_var;
            default:   div_dividend = r_var;
        endcase
        div_divisor = (i_cmd.div_sel == DIV_BSUM) ? {{(DVSR_W-LEN_W){1'b0}}, len} : r_bcnt;
    end

    // one 32x32 multiplier: block mean squares, or 24-bit halves of the finish mean
    always_comb begin
        if (i_cmd.cl_mul) begin
            mul_a = quot[31:0];
            mul_b = quot[31:0];
        end else begin
            case (i_cmd.mul_step)
                2'd0: begin
                    mul_a = {8'd0, r_m1mag[23:0]};
                    mul_b = {8'd0, r_m1mag[23:0]};
                end
                2'd1: begin
                    mul_a = {8'd0, r_m1mag[47:24]};
                    mul_b = {8'd0, r_m1mag[23:0]};
                end
                default: begin
                    mul_a = {8'd0, r_m1mag[47:24]};
                    mul_b = {8'd0, r_m1mag[47:24]};
                end
            endcase
        end
    end

    mbee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    assign o_sts.close_req = !warming && i_row_end &&
                             (({1'b0, r_rib} + 1'b1) >= {1'b0, len});
    assign o_sts.div_busy  = div_busy;
    assign o_sts.out_free  = out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_len <= LEN_W'(1);
            r_warm    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_LENGTH: r_blk_len <= i_cfg_data[LEN_W-1:0];
                REG_WARMUP_ROWS:  r_warm    <= i_cfg_data[WARM_W-1:0];
                default: ;
            endcase
        end
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_rib  <= '0;
            r_skip <= '0;
            r_bcnt <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_bsum[c]  <= '0;
                r_msum[c]  <= '0;
                r_sqsum[c] <= '0;
            end
        end else begin
            if (i_cmd.sample) begin
                if (warming) begin
                    if (i_row_end) begin
                        r_skip <= r_skip + 1'b1;
                    end
                end else begin
                    if (ch_ok) begin
                        r_bsum[sidx] <= r_bsum[sidx] +
                            {{(BSUM_W-SAMPLE_W){i_sample_value[SAMPLE_W-1]}}, i_sample_value};
                    end
                    if (i_row_end) begin
                        r_rib <= o_sts.close_req ? '0 : r_rib + 1'b1;
                    end
                end
            end
            if (i_cmd.cl_acc) begin
                if (r_bcnt != CNT_FULL) begin
                    r_msum[i_ch_idx]  <= r_msum[i_ch_idx] +
                        {{(MSUM_W-BSUM_W){r_m[BSUM_W-1]}}, r_m};
                    r_sqsum[i_ch_idx] <= r_sqsum[i_ch_idx] + r_prod;
                end
                r_bsum[i_ch_idx] <= '0;
            end
            if (i_cmd.blk_done && r_bcnt != CNT_FULL) begin
                r_bcnt <= r_bcnt + 1'b1;
            end
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cl_mul) begin
            r_prod <= mul_a * mul_b;
            r_m    <= cur_bsum[BSUM_W-1] ? (~quot[31:0] + 1'b1) : quot[31:0];
        end
        if (i_cmd.lat_m1) begin
            r_m1mag <= quot[MSUM_W-1:0];
            r_m1    <= cur_msum[MSUM_W-1] ? signed'(~quot[MSUM_W-1:0] + 1'b1)
                                          : signed'(quot[MSUM_W-1:0]);
        end
        if (i_cmd.mul_step_en) begin
            case (i_cmd.mul_step)
                2'd0: begin
                    r_prod <= mul_a * mul_b;
                    r_m2   <= quot;
                end
                2'd1: begin
                    r_prod <= mul_a * mul_b;
                    r_sq   <= r_prod;
                end
                2'd2: begin
                    r_prod <= mul_a * mul_b;
                    r_sq   <= r_sq + {r_prod[38:0], 25'd0};
                end
                default: begin
                    r_sq <= r_sq + {r_prod[15:0], 48'd0};
                end
            endcase
        end
        if (i_cmd.var_calc) begin
            r_var <= (r_m2 > r_sq) ? (r_m2 - r_sq) : 64'd0;
        end
        if (i_cmd.sq_init) begin
            r_x   <= quot;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sq_step) begin
            if (r_x >= sq_trial) begin
                r_x   <= r_x - sq_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_channel <= 4'(i_ch_idx);
            o_blocks_used <= r_bcnt;
            o_stats_valid <= r_bcnt != '0;
            o_last_result <= i_cmd.out_last;
            if (r_bcnt == '0) begin
                o_mean_value <= '0;
                o_std_error  <= '0;
            end else begin
                if (r_m1 > 48'sd8388607) begin
                    o_mean_value <= 24'sh7FFFFF;
                end else if (r_m1 < -48'sd8388608) begin
                    o_mean_value <= 24'sh800000;
                end else begin
                    o_mean_value <= r_m1[MEAN_W-1:0];
                end
                o_std_error <= (r_res > 64'd8388607) ? '1 : r_res[STD_W-1:0];
            end
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire

### hdl/mbee_ctrl.sv
// controller: sequences sample intake, block close and the finish report
`default_nettype none
module mbee_ctrl #(
    parameter int CHANNELS = 16,
    parameter int CW       = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_command,
    output logic                o_in_stall,
    input  wire mbee_pkg::t_sts i_sts,
    output mbee_pkg::t_cmd      o_cmd,
    output logic [CW-1:0]       o_ch_idx
);
    import mbee_pkg::*;

    localparam int NOUT = (CHANNELS < 16) ? CHANNELS : 16;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_CDIV  = 16'h0002,
        S_CWAIT = 16'h0004,
        S_CMUL  = 16'h0008,
        S_CACC  = 16'h0010,
        S_FDIV1 = 16'h0020,
        S_FW1   = 16'h0040,
        S_FDIV2 = 16'h0080,
        S_FW2   = 16'h0100,
        S_FMUL  = 16'h0200,
        S_FVAR  = 16'h0400,
        S_FDIV3 = 16'h0800,
        S_FW3   = 16'h1000,
        S_FSQI  = 16'h2000,
        S_FSQRT = 16'h4000,
        S_FOUT  = 16'h8000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_ch, n_ch;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.div_sel  = DIV_BSUM;
        o_cmd.mul_step = r_step[1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ch = '0;
                    if (i_command == CMD_SAMPLE) begin
                        o_cmd.sample = 1'b1;
                        if (i_sts.close_req) begin
                            n_state = S_CDIV;
                        end
                    end else begin
                        n_state = S_FDIV1;
                    end
                end
            end
            S_CDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_BSUM;
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                o_cmd.div_sel = DIV_BSUM;
                if (!i_sts.div_busy) begin
                    n_state = S_CMUL;
                end
            end
            S_CMUL: begin
                o_cmd.cl_mul = 1'b1;
                n_state = S_CACC;
            end
            S_CACC: begin
                o_cmd.cl_acc = 1'b1;
                if (r_ch == CW'(CHANNELS - 1)) begin
                    o_cmd.blk_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_CDIV;
                end
            end
            S_FDIV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MSUM;
                n_state = S_FW1;
            end
            S_FW1: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FDIV2;
                end
            end
            S_FDIV2: begin
                o_cmd.lat_m1    = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SQSUM;
                n_state = S_FW2;
            end
            S_FW2: begin
                if (!i_sts.div_busy) begin
                    n_step  = '0;
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                o_cmd.mul_step_en = 1'b1;
                if (r_step == STEP_W'(3)) begin
                    n_state = S_FVAR;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FVAR: begin
                o_cmd.var_calc = 1'b1;
                n_state = S_FDIV3;
            end
            S_FDIV3: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VAR;
                n_state = S_FW3;
            end
            S_FW3: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FSQI;
                end
            end
            S_FSQI: begin
                o_cmd.sq_init = 1'b1;
                n_step  = '0;
                n_state = S_FSQRT;
            end
            S_FSQRT: begin
                o_cmd.sq_step = 1'b1;
                if (r_step == '1) begin
                    n_state = S_FOUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_ch == CW'(NOUT - 1)) begin
                        o_cmd.out_last  = 1'b1;
                        o_cmd.clear_all = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_FDIV1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = r_state != S_IDLE;
    assign o_ch_idx   = r_ch;
endmodule
`default_nettype wire

### hdl/multichannel_blocking_error_estimator.sv
// top level of the multichannel blocking standard-error estimator
// a sample word that closes no block leaves the controller idle; one that closes a block
// walks every channel through the shared divider, then the multiplier and the sums
// a finish word runs three divides, a 4-step square and a 32-step root per channel,
// and may wait on the result stall before each reported channel is loaded
// synchronous active-low reset clears all sums and counters; block_length resets to 1
`default_nettype none
module multichannel_blocking_error_estimator #(
    parameter int CHANNELS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [mbee_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mbee_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input words
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_command,
    input  wire logic [3:0]                            i_channel,
    input  wire logic signed [mbee_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  wire logic                                  i_row_end,
    // result words
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [3:0]                                 o_out_channel,
    output logic signed [mbee_pkg::MEAN_W-1:0]         o_mean_value,
    output logic [mbee_pkg::STD_W-1:0]                 o_std_error,
    output logic [mbee_pkg::CNT_W-1:0]                 o_blocks_used,
    output logic                                       o_stats_valid,
    output logic                                       o_last_result
);
    import mbee_pkg::*;

    // channel counter width, at least one bit
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [CW-1:0] ch_idx;

    // controller: intake while idle, channel walks for block close and finish
    mbee_ctrl #(
        .CHANNELS (CHANNELS),
        .CW       (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ch_idx   (ch_idx)
    );

    // datapath: sums, shared divider, multiplier, root and the result register
    mbee_dp #(
        .CHANNELS (CHANNELS),
        .CW       (CW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_ch_idx       (ch_idx),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_channel      (i_channel),
        .i_sample_value (i_sample_value),
        .i_row_end      (i_row_end),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_channel  (o_out_channel),
        .o_mean_value   (o_mean_value),
        .o_std_error    (o_std_error),
        .o_blocks_used  (o_blocks_used),
        .o_stats_valid  (o_stats_valid),
        .o_last_result  (o_last_result)
    );
endmodule
`default_nettype wire
